// ----- rtl/tpf_pkg.sv -----
package tpf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PERIOD_BITS = 25;
  localparam int SPEED_W     = 14;
  localparam int COEF_W      = 16;
  localparam int FILT_W      = SPEED_W + FRAC_BITS;
  localparam int DIFF_W      = FILT_W + 1;
  localparam int PROD_W      = DIFF_W + COEF_W + 1;
  localparam int CNT_W       = $clog2(PERIOD_BITS);
  localparam int CFG_IDX_W   = 3;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_PER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL_SPD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_COEF = 3'd4;

  localparam logic [PERIOD_BITS-1:0] RATE_NUM_RST  = PERIOD_BITS'(20000000);
  localparam logic [PERIOD_BITS-1:0] STALL_PER_RST = PERIOD_BITS'(20000000);
  localparam logic [PERIOD_BITS-1:0] MIN_PER_RST   = PERIOD_BITS'(2000);
  localparam logic [SPEED_W-1:0]     CEIL_SPD_RST  = SPEED_W'(10000);
  localparam logic [COEF_W-1:0]      FILT_COEF_RST = COEF_W'(10394);

  typedef struct packed {
    logic load;      // capture period, classify, start divide
    logic div_step;  // one restoring divide step
    logic raw_en;    // register raw speed and filter difference
    logic mul_en;    // register coefficient product
    logic commit;    // update filter, load output registers
  } tpf_cmd_t;

endpackage

// ----- rtl/tpf_ctrl.sv -----
module tpf_ctrl
  import tpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tpf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RAW  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PERIOD_BITS - 1)) state_nxt = S_RAW;
      end
      S_RAW: begin
        cmd.raw_en = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/tpf_dp.sv -----
module tpf_dp
  import tpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  tpf_cmd_t               cmd,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PERIOD_BITS-1:0] cfg_data,
  input  logic [PERIOD_BITS-1:0] in_period_us,
  output logic [SPEED_W-1:0]     out_speed_filtered,
  output logic [SPEED_W-1:0]     out_speed_raw,
  output logic                   out_stalled,
  output logic                   out_over_limit
);

  // configuration
  logic [PERIOD_BITS-1:0] rate_num_r, stall_per_r, min_per_r;
  logic [SPEED_W-1:0]     ceil_spd_r;
  logic [COEF_W-1:0]      coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_num_r  <= RATE_NUM_RST;
      stall_per_r <= STALL_PER_RST;
      min_per_r   <= MIN_PER_RST;
      ceil_spd_r  <= CEIL_SPD_RST;
      coef_r      <= FILT_COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE_NUM:  rate_num_r  <= cfg_data;
        REG_STALL_PER: stall_per_r <= cfg_data;
        REG_MIN_PER:   min_per_r   <= cfg_data;
        REG_CEIL_SPD:  ceil_spd_r  <= cfg_data[SPEED_W-1:0];
        REG_FILT_COEF: coef_r      <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // classification and restoring divider
  logic [PERIOD_BITS-1:0] divisor_r, quot_r, rem_r;
  logic                   stalled_r, over_r;
  logic [PERIOD_BITS:0]   rem_sh;
  logic [PERIOD_BITS+1:0] trial;
  logic                   stall_c, over_c;

  assign stall_c = (in_period_us > stall_per_r);
  assign over_c  = !stall_c && ((in_period_us < min_per_r) || (in_period_us == '0));
  assign rem_sh  = {rem_r, quot_r[PERIOD_BITS-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, divisor_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor_r <= in_period_us;
      quot_r    <= rate_num_r;
      rem_r     <= '0;
      stalled_r <= stall_c;
      over_r    <= over_c;
    end else if (cmd.div_step) begin
      if (!trial[PERIOD_BITS+1]) begin
        rem_r  <= trial[PERIOD_BITS-1:0];
        quot_r <= {quot_r[PERIOD_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[PERIOD_BITS-1:0];
        quot_r <= {quot_r[PERIOD_BITS-2:0], 1'b0};
      end
    end
  end

  // raw speed and low-pass filter
  logic [SPEED_W-1:0]       raw_c, raw_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r, step_c;
  logic [FILT_W-1:0]        filt_r;
  logic [PROD_W-1:0]        sum_c;

  always_comb begin
    priority if (stalled_r) raw_c = '0;
    else if (over_r)        raw_c = ceil_spd_r;
    else if (quot_r[PERIOD_BITS-1:SPEED_W] != '0) raw_c = SPEED_MAX;
    else                    raw_c = quot_r[SPEED_W-1:0];
  end

  assign step_c = prod_r >>> COEF_W;
  assign sum_c  = PROD_W'(filt_r) + PROD_W'(step_c);

  always_ff @(posedge clk) begin
    if (cmd.raw_en) begin
      raw_r  <= raw_c;
      diff_r <= $signed({1'b0, raw_c, {FRAC_BITS{1'b0}}}) - $signed({1'b0, filt_r});
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(diff_r * $signed({1'b0, coef_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (cmd.commit) begin
      filt_r <= sum_c[FILT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_speed_filtered <= sum_c[FILT_W-1:FRAC_BITS];
      out_speed_raw      <= raw_r;
      out_stalled        <= stalled_r;
      out_over_limit     <= over_r;
    end
  end

endmodule

// ----- rtl/tachometer_period_filter_unit.sv -----
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_period_us[24:0]
// out     | output    | out_valid / out_ready | out_speed_filtered, out_speed_raw,
//         |           |                       | out_stalled, out_over_limit
// cfg     | input     | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[24:0]
//
// One item at a time: the period is captured at the accepting edge, then 25 restoring
// divide steps (one quotient bit each), raw speed, multiply and filter update follow in
// turn; out_valid rises with the filter update and in_ready returns with it.
// A waiting result does not block the next item; that item's filter update holds until
// the old result is taken. Reset (rst_n low, synchronous) restores register defaults
// and zeroes the filter. cfg_ready is always high; writes to unknown indexes are dropped.
module tachometer_period_filter_unit
  import tpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PERIOD_BITS-1:0] in_period_us,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SPEED_W-1:0]     out_speed_filtered,
  output logic [SPEED_W-1:0]     out_speed_raw,
  output logic                   out_stalled,
  output logic                   out_over_limit,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PERIOD_BITS-1:0] cfg_data
);

  tpf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer: divide count, stage order, output valid
  tpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // registers, divider, filter and output register
  tpf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_period_us       (in_period_us),
    .out_speed_filtered (out_speed_filtered),
    .out_speed_raw      (out_speed_raw),
    .out_stalled        (out_stalled),
    .out_over_limit     (out_over_limit)
  );

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tpf_pkg::*;

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 40;   // a little over the accept-to-result path
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 138;

  // one expected result item
  typedef struct packed {
    logic [SPEED_W-1:0] speed_filtered;
    logic [SPEED_W-1:0] speed_raw;
    logic               stalled;
    logic               over_limit;
  } speed_rec_t;

  // Own copy of the registers and the low-pass accumulator; predicts one
  // result per accepted period and checks results in order.
  class tach_checker;
    logic [PERIOD_BITS-1:0] rate_num, stall_per, min_per;
    logic [SPEED_W-1:0]     ceil_spd;
    logic [COEF_W-1:0]      coef;
    logic [FILT_W-1:0]      filt_acc;
    speed_rec_t             expected_speeds[$];
    int errors, periods_in, results_seen, n_stalled, n_clamped;

    function new();
      rate_num  = RATE_NUM_RST;
      stall_per = STALL_PER_RST;
      min_per   = MIN_PER_RST;
      ceil_spd  = CEIL_SPD_RST;
      coef      = FILT_COEF_RST;
      filt_acc  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_BITS-1:0] val);
      case (idx)
        REG_RATE_NUM:  rate_num  = val;
        REG_STALL_PER: stall_per = val;
        REG_MIN_PER:   min_per   = val;
        REG_CEIL_SPD:  ceil_spd  = val[SPEED_W-1:0];
        REG_FILT_COEF: coef      = val[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // classify, divide, then filter: new = old + floor(coef * (raw - old) / 2^16)
    function void note_period(logic [PERIOD_BITS-1:0] p);
      speed_rec_t             e;
      logic [PERIOD_BITS-1:0] quot;
      logic [SPEED_W-1:0]     raw;
      longint                 diff, prod;
      e = '0;
      if (p > stall_per) begin
        raw = '0;
        e.stalled = 1'b1;
        n_stalled++;
      end else if (p < min_per || p == '0) begin
        raw = ceil_spd;
        e.over_limit = 1'b1;
        n_clamped++;
      end else begin
        quot = rate_num / p;
        raw  = (quot > PERIOD_BITS'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
      end
      diff = (longint'(raw) << FRAC_BITS) - longint'(filt_acc);
      prod = diff * longint'(coef);
      filt_acc = FILT_W'(longint'(filt_acc) + (prod >>> COEF_W));
      e.speed_filtered = filt_acc[FILT_W-1 -: SPEED_W];
      e.speed_raw      = raw;
      expected_speeds.push_back(e);
      periods_in++;
    endfunction

    function int outstanding();
      return expected_speeds.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(speed_rec_t got);
      speed_rec_t want;
      results_seen++;
      if (expected_speeds.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_speeds.pop_front();
        if (got.speed_filtered !== want.speed_filtered)
          report($sformatf("result %0d speed_filtered got %0d want %0d", results_seen,
                           got.speed_filtered, want.speed_filtered));
        if (got.speed_raw !== want.speed_raw)
          report($sformatf("result %0d speed_raw got %0d want %0d", results_seen,
                           got.speed_raw, want.speed_raw));
        if (got.stalled !== want.stalled)
          report($sformatf("result %0d stalled got %0b want %0b", results_seen,
                           got.stalled, want.stalled));
        if (got.over_limit !== want.over_limit)
          report($sformatf("result %0d over_limit got %0b want %0b", results_seen,
                           got.over_limit, want.over_limit));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PERIOD_BITS-1:0] in_period_us = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SPEED_W-1:0]     out_speed_filtered;
  logic [SPEED_W-1:0]     out_speed_raw;
  logic                   out_stalled;
  logic                   out_over_limit;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_RATE_NUM;
  logic [PERIOD_BITS-1:0] cfg_data = '0;

  tach_checker sb = new();
  bit snd_jitter = 1'b1;   // sender may drop valid between items
  bit rcv_jitter = 1'b1;   // receiver may drop ready in bursts
  int settings_used = 1;   // reset values count as the first setting
  int cycles = 0;

  tachometer_period_filter_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, sb.outstanding());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: ready drops in bursts while jitter is on.
  int ready_hold = 0;
  always @(posedge clk) begin
    if (ready_hold > 0)
      ready_hold--;
    else if (rcv_jitter && $urandom_range(0, 5) == 0)
      ready_hold = $urandom_range(1, 7);
    out_ready <= (ready_hold == 0);
  end

  // Results are sampled on the edge that accepts them (pre-update values).
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_speed_filtered, out_speed_raw, out_stalled, out_over_limit});
  end

  // Present one period and hold it until taken. A zero gap keeps valid high
  // straight into the next item.
  task automatic send_period(logic [PERIOD_BITS-1:0] p);
    int gap;
    in_valid     <= 1'b1;
    in_period_us <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_period(p);
    gap = (snd_jitter && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender stops and waits for every outstanding item; the block is idle after.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PERIOD_BITS-1:0] pick_wide(logic [PERIOD_BITS-1:0] lo);
    case ($urandom_range(0, 4))
      0:       return lo;
      1:       return PERIOD_MAX;
      2:       return PERIOD_BITS'(20000000);
      3:       return PERIOD_BITS'($urandom());
      default: return PERIOD_BITS'($urandom_range(1, 1000000));
    endcase
  endfunction

  // New random setting; extremes turn up often. Stall mostly sits above min.
  task automatic reconfigure();
    logic [PERIOD_BITS-1:0] v;
    if ($urandom_range(0, 2) != 0) write_reg(REG_RATE_NUM, pick_wide(PERIOD_BITS'(1)));
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = PERIOD_BITS'($urandom_range(0, 5000));  // min of zero: period 0 clamps
        2:       v = PERIOD_MAX;
        default: v = PERIOD_BITS'($urandom_range(1, 5000));
      endcase
      write_reg(REG_MIN_PER, v);
    end
    if ($urandom_range(0, 2) != 0) begin
      v = pick_wide('0);
      if ($urandom_range(0, 3) != 0 && v < sb.min_per)
        v = sb.min_per + PERIOD_BITS'($urandom_range(0, 100000));
      write_reg(REG_STALL_PER, v);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 2))
        0:       v = '0;
        1:       v = PERIOD_BITS'(SPEED_MAX);
        default: v = PERIOD_BITS'($urandom_range(0, 16383));
      endcase
      write_reg(REG_CEIL_SPD, v);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 4))
        0:       v = '0;
        1:       v = PERIOD_BITS'(16'hFFFF);
        2:       v = PERIOD_BITS'(FILT_COEF_RST);
        default: v = PERIOD_BITS'($urandom_range(0, 65535));
      endcase
      write_reg(REG_FILT_COEF, v);
    end
    settings_used++;
  endtask

  // Periods weighted towards the interesting places: quotient band, both
  // thresholds, zero/one/max, plus plain random for bit coverage.
  function automatic logic [PERIOD_BITS-1:0] pick_period();
    logic [PERIOD_BITS-1:0] base;
    case ($urandom_range(0, 9))
      0: return PERIOD_BITS'($urandom());
      1: return PERIOD_BITS'(longint'(sb.min_per) + $urandom_range(0, 6) - 3);
      2: return PERIOD_BITS'(longint'(sb.stall_per) + $urandom_range(0, 6) - 3);
      3: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return PERIOD_BITS'(1);
          default: return PERIOD_MAX;
        endcase
      end
      default: begin
        // spread over the band where rate/period lands in or just above the speed range
        base = sb.rate_num >> $urandom_range(0, 15);
        return base + PERIOD_BITS'($urandom_range(0, base >> 2));
      end
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: below min, the min edge, quotient, stall edge and beyond.
    send_period('0);
    send_period(PERIOD_BITS'(1999));
    send_period(PERIOD_BITS'(2000));
    send_period(PERIOD_BITS'(2001));
    send_period(PERIOD_BITS'(40000));
    send_period(PERIOD_BITS'(20000000));
    send_period(PERIOD_BITS'(20000001));
    send_period(PERIOD_MAX);
    send_period(PERIOD_BITS'(1));
    drain();

    // Top of every range: huge quotients saturate without the clamp flag.
    write_reg(REG_RATE_NUM, PERIOD_MAX);
    write_reg(REG_STALL_PER, PERIOD_MAX);
    write_reg(REG_MIN_PER, PERIOD_BITS'(1));
    write_reg(REG_CEIL_SPD, PERIOD_BITS'(SPEED_MAX));
    write_reg(REG_FILT_COEF, PERIOD_BITS'(16'hFFFF));
    settings_used++;
    send_period(PERIOD_BITS'(1));
    send_period(PERIOD_BITS'(2048));
    send_period(PERIOD_BITS'(4096));
    send_period(PERIOD_MAX);
    send_period('0);
    drain();

    // Bottom of every range, min of zero: period 0 clamps, no divide; coef 0 holds.
    write_reg(REG_RATE_NUM, PERIOD_BITS'(1));
    write_reg(REG_STALL_PER, '0);
    write_reg(REG_MIN_PER, '0);
    write_reg(REG_CEIL_SPD, '0);
    write_reg(REG_FILT_COEF, '0);
    settings_used++;
    send_period('0);
    send_period(PERIOD_BITS'(1));
    send_period(PERIOD_MAX);
    drain();

    // Stall limit below min: where both apply, stall wins and over_limit stays low.
    write_reg(REG_RATE_NUM, PERIOD_BITS'(20000000));
    write_reg(REG_STALL_PER, PERIOD_BITS'(100));
    write_reg(REG_MIN_PER, PERIOD_BITS'(1000));
    write_reg(REG_CEIL_SPD, PERIOD_BITS'(5000));
    write_reg(REG_FILT_COEF, PERIOD_BITS'(32768));
    settings_used++;
    send_period(PERIOD_BITS'(500));
    send_period(PERIOD_BITS'(100));
    send_period(PERIOD_BITS'(101));
    send_period(PERIOD_BITS'(50));
    drain();

    write_reg(REG_MIN_PER, '0);
    write_reg(REG_STALL_PER, PERIOD_MAX);
    settings_used++;
    send_period('0);
    send_period(PERIOD_BITS'(1));
    drain();

    // Random phases; jitter varies per phase and is off for the last one.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      reconfigure();
      snd_jitter = (ph % 3 != 2) && (ph != RAND_PHASES - 1);
      rcv_jitter = (ph % 4 != 3) && (ph != RAND_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_period(pick_period());
        // once per phase with sender jitter on, hold off until everything in flight has come back
        if (k == PHASE_ITEMS / 2 && snd_jitter) begin
          in_valid <= 1'b0;
          while (sb.outstanding() != 0) @(posedge clk);
        end
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    $display("covered %0d periods over %0d register settings, %0d results checked",
             sb.periods_in, settings_used, sb.results_seen);
    $display("  of those %0d stalled and %0d clamped to the ceiling; %0d mismatches",
             sb.n_stalled, sb.n_clamped, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tpf_pkg.sv
rtl/tpf_ctrl.sv
rtl/tpf_dp.sv
rtl/tachometer_period_filter_unit.sv
tb/testbench.sv
